### src/rbc_pkg.sv
`default_nettype none

package rbc_pkg;

	localparam int VALUE_BITS          = 32;
	localparam int MAX_INPUT_DIGITS    = 32;
	localparam int MAX_FRACTION_DIGITS = 32;
	localparam int OUT_CAP             = 32;

	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int BASE_W     = 5;
	localparam int FCNT_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam int DEN_W      = VALUE_BITS + 1;
	localparam int PROD_W     = VALUE_BITS + BASE_W;
	localparam int DEN_PROD_W = DEN_W + BASE_W;
	localparam int CNT_W      = $clog2(MAX_INPUT_DIGITS + 1);
	localparam int BUF_IDX_W  = $clog2(OUT_CAP);
	localparam int FRAC_CAP   = (MAX_FRACTION_DIGITS < OUT_CAP) ? MAX_FRACTION_DIGITS : OUT_CAP;
	localparam int FIDX_W     = $clog2(FRAC_CAP);
	localparam int FQ_CNT_W   = $clog2(DIGIT_W);

	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = VALUE_BITS / DIV_STEPS;
	localparam int DCNT_W     = $clog2(DIV_CYCLES);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [DEN_PROD_W-1:0] DEN_LIMIT = DEN_PROD_W'(1) << VALUE_BITS;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'd70;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'd102;
	localparam logic [DIGIT_W-1:0] LETTER_BASE = 4'd10;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	localparam logic [BASE_W-1:0] SRC_BASE_RST = 5'd10;
	localparam logic [BASE_W-1:0] TGT_BASE_RST = 5'd2;
	localparam logic [FCNT_W-1:0] FDIG_RST     = 6'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_BASE,
		CFG_TARGET_BASE,
		CFG_FRACTION_MODE,
		CFG_FRACTION_DIGITS
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_TAKE,
		ST_FINAL,
		ST_FLAG,
		ST_IDIV,
		ST_IREAD,
		ST_IEMIT,
		ST_FMUL,
		ST_FDIV,
		ST_FEMIT
	} back_state_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] value;
		logic               bad;
		logic               last;
	} tok_t;

	typedef struct packed {
		logic [BASE_W-1:0] src_base;
		logic [BASE_W-1:0] tgt_base;
		logic              frac;
		logic [FCNT_W-1:0] fcount;
	} cfg_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN)
			r = BASE_MIN;
		else if (b > BASE_MAX)
			r = BASE_MAX;
		return r;
	endfunction

	function automatic logic [FCNT_W-1:0] clamp_fcount(input logic [FCNT_W-1:0] n);
		logic [FCNT_W-1:0] r;
		r = n;
		if (n == '0)
			r = FCNT_W'(1);
		else if (n > FCNT_W'(FRAC_CAP))
			r = FCNT_W'(FRAC_CAP);
		return r;
	endfunction

endpackage

`default_nettype wire

### src/rbc_if.sv
`default_nettype none

interface rbc_char_if;
	logic                        valid;
	logic                        ready;
	logic [rbc_pkg::CHAR_W-1:0]  character;
	logic                        last_char;

	modport source(output valid, character, last_char, input ready);
	modport sink(input valid, character, last_char, output ready);
endinterface

interface rbc_digit_if;
	logic                        valid;
	logic                        ready;
	logic [rbc_pkg::DIGIT_W-1:0] digit;
	logic                        last_digit;
	logic                        bad_digit;
	logic                        overflow;

	modport source(output valid, digit, last_digit, bad_digit, overflow, input ready);
	modport sink(input valid, digit, last_digit, bad_digit, overflow, output ready);
endinterface

`default_nettype wire

### src/radix_base_converter.sv
`default_nettype none

// Converts an ASCII digit string (0-9, A-F, a-f; one character per request, last_char on
// the final one) from source_base to target_base, as an integer or as a fraction 0.ddd.
// Characters pass a 4-entry queue and are folded in at one per cycle while the back end is
// in ST_TAKE; a last character yields its results after the back end works them out.
// Integer mode: each target digit comes from the divide unit (4 quotient bits per cycle
// over the 32-bit value), then digits leave most significant first through the registered
// digit buffer read. Fraction mode: fraction_digits digits, each from one multiply by the
// base, four restoring subtract steps and one output load. A bad character or an overflow
// gives one flagged zero digit, by way of ST_FINAL and ST_FLAG after the last character.
// An output register lets the queue keep filling while a result waits to be taken.
module radix_base_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data,
	rbc_char_if.sink                       chars,
	rbc_digit_if.source                    digits
);

	logic [rbc_pkg::BASE_W-1:0] src_base_q;
	logic [rbc_pkg::BASE_W-1:0] tgt_base_q;
	logic                       frac_mode_q;
	logic [rbc_pkg::FCNT_W-1:0] frac_digits_q;

	rbc_pkg::cfg_t cfg;
	rbc_pkg::tok_t front_tok;
	rbc_pkg::tok_t back_tok;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q    <= rbc_pkg::SRC_BASE_RST;
			tgt_base_q    <= rbc_pkg::TGT_BASE_RST;
			frac_mode_q   <= 1'b0;
			frac_digits_q <= rbc_pkg::FDIG_RST;
		end else if (cfg_write) begin
			unique case (rbc_pkg::cfg_idx_t'(cfg_index))
				rbc_pkg::CFG_SOURCE_BASE:     src_base_q    <= cfg_data[rbc_pkg::BASE_W-1:0];
				rbc_pkg::CFG_TARGET_BASE:     tgt_base_q    <= cfg_data[rbc_pkg::BASE_W-1:0];
				rbc_pkg::CFG_FRACTION_MODE:   frac_mode_q   <= cfg_data[0];
				rbc_pkg::CFG_FRACTION_DIGITS: frac_digits_q <= cfg_data[rbc_pkg::FCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.src_base = rbc_pkg::clamp_base(src_base_q);
		cfg.tgt_base = rbc_pkg::clamp_base(tgt_base_q);
		cfg.frac     = frac_mode_q;
		cfg.fcount   = rbc_pkg::clamp_fcount(frac_digits_q);
	end

	rbc_front u_front (
		.chars    (chars),
		.src_base (cfg.src_base),
		.full     (full),
		.push     (push),
		.tok      (front_tok)
	);

	rbc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_tok),
		.pop    (pop),
		.rdata  (back_tok),
		.full   (full),
		.empty  (empty)
	);

	rbc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tok    (back_tok),
		.empty  (empty),
		.pop    (pop),
		.digits (digits)
	);

endmodule

`default_nettype wire

### src/rbc_front.sv
`default_nettype none

module rbc_front (
	rbc_char_if.sink                   chars,
	input  logic [rbc_pkg::BASE_W-1:0] src_base,
	input  logic                       full,
	output logic                       push,
	output rbc_pkg::tok_t              tok
);

	logic                         is_dec;
	logic                         is_upper;
	logic                         is_lower;
	logic [rbc_pkg::CHAR_W-1:0]   off;

	always_comb begin
		is_dec   = (chars.character >= rbc_pkg::CHAR_ZERO) &&
			(chars.character <= rbc_pkg::CHAR_NINE);
		is_upper = (chars.character >= rbc_pkg::CHAR_UPPER_A) &&
			(chars.character <= rbc_pkg::CHAR_UPPER_F);
		is_lower = (chars.character >= rbc_pkg::CHAR_LOWER_A) &&
			(chars.character <= rbc_pkg::CHAR_LOWER_F);

		off = '0;
		if (is_dec)
			off = chars.character - rbc_pkg::CHAR_ZERO;
		else if (is_upper)
			off = chars.character - rbc_pkg::CHAR_UPPER_A;
		else if (is_lower)
			off = chars.character - rbc_pkg::CHAR_LOWER_A;

		tok.value = is_dec ? off[rbc_pkg::DIGIT_W-1:0] :
			off[rbc_pkg::DIGIT_W-1:0] + rbc_pkg::LETTER_BASE;
		tok.bad   = !(is_dec || is_upper || is_lower) ||
			({1'b0, tok.value} >= src_base);
		tok.last  = chars.last_char;
	end

	assign chars.ready = !full;
	assign push        = chars.valid && !full;

endmodule

`default_nettype wire

### src/rbc_fifo.sv
`default_nettype none

module rbc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rbc_pkg::tok_t wdata,
	input  logic          pop,
	output rbc_pkg::tok_t rdata,
	output logic          full,
	output logic          empty
);

	rbc_pkg::tok_t                 slot_q [rbc_pkg::QDEPTH];
	logic [rbc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [rbc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [rbc_pkg::QCNT_W-1:0]    count_q;

	assign full  = (count_q == rbc_pkg::QCNT_W'(rbc_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + rbc_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + rbc_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + rbc_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - rbc_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

### src/rbc_back.sv
`default_nettype none

module rbc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rbc_pkg::cfg_t cfg,
	input  rbc_pkg::tok_t tok,
	input  logic          empty,
	output logic          pop,
	rbc_digit_if.source   digits
);

	rbc_pkg::back_state_t state_q, state_d;

	logic [rbc_pkg::VALUE_BITS-1:0] acc_q;
	logic [rbc_pkg::DEN_W-1:0]      den_q;
	logic [rbc_pkg::CNT_W-1:0]      cnt_q;
	logic                           err_q;
	logic                           ovf_q;

	logic [rbc_pkg::VALUE_BITS-1:0] quo_q;
	logic [rbc_pkg::DIGIT_W-1:0]    rem_q;
	logic [rbc_pkg::BUF_IDX_W-1:0]  n_q;
	logic [rbc_pkg::DCNT_W-1:0]     dstep_q;
	logic [rbc_pkg::DIGIT_W-1:0]    digit_mem [rbc_pkg::OUT_CAP];
	logic [rbc_pkg::DIGIT_W-1:0]    rdata_q;

	logic [rbc_pkg::VALUE_BITS-1:0] r_q;
	logic [rbc_pkg::PROD_W-1:0]     prod_q;
	logic [rbc_pkg::FQ_CNT_W-1:0]   k_q;
	logic [rbc_pkg::DIGIT_W-1:0]    fq_q;
	logic [rbc_pkg::FIDX_W-1:0]     fi_q;

	logic                           out_valid_q;
	logic [rbc_pkg::DIGIT_W-1:0]    out_digit_q;
	logic                           out_last_q;
	logic                           out_bad_q;
	logic                           out_ovf_q;

	logic [rbc_pkg::PROD_W-1:0]     acc_new;
	logic [rbc_pkg::DEN_PROD_W-1:0] den_mul;
	logic                           int_ovf;
	logic                           frac_ovf;
	logic                           fin_ovf;

	logic [rbc_pkg::VALUE_BITS-1:0] quo_nx;
	logic [rbc_pkg::DIGIT_W-1:0]    rem_nx;
	logic [rbc_pkg::BASE_W-1:0]     trial;
	logic                           div_last;

	logic [rbc_pkg::PROD_W-1:0]     den_sh;
	logic                           ge;
	logic [rbc_pkg::PROD_W-1:0]     prod_nx;
	logic                           f_last;

	logic                           out_free;
	logic                           out_load;
	logic [rbc_pkg::DIGIT_W-1:0]    o_digit;
	logic                           o_last;
	logic                           o_bad;
	logic                           o_ovf;
	logic                           done;

	// Horner step and limit checks for one digit
	always_comb begin
		acc_new  = rbc_pkg::PROD_W'(acc_q) * rbc_pkg::PROD_W'(cfg.src_base) +
			rbc_pkg::PROD_W'(tok.value);
		den_mul  = rbc_pkg::DEN_PROD_W'(den_q) * rbc_pkg::DEN_PROD_W'(cfg.src_base);
		int_ovf  = |acc_new[rbc_pkg::PROD_W-1:rbc_pkg::VALUE_BITS];
		frac_ovf = (rbc_pkg::DEN_W'(acc_q) >= den_q) || (den_mul > rbc_pkg::DEN_LIMIT);
		fin_ovf  = ovf_q || (!err_q && cfg.frac && (rbc_pkg::DEN_W'(acc_q) >= den_q));
	end

	// Divide by target base, several quotient bits per cycle
	always_comb begin
		quo_nx = quo_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int j = 0; j < rbc_pkg::DIV_STEPS; j++) begin
			trial  = {rem_nx, quo_nx[rbc_pkg::VALUE_BITS-1]};
			quo_nx = {quo_nx[rbc_pkg::VALUE_BITS-2:0], 1'b0};
			if (trial >= cfg.tgt_base) begin
				trial     = trial - cfg.tgt_base;
				quo_nx[0] = 1'b1;
			end
			rem_nx = trial[rbc_pkg::DIGIT_W-1:0];
		end
		div_last = (dstep_q == rbc_pkg::DCNT_W'(rbc_pkg::DIV_CYCLES - 1));
	end

	// One restoring step of the fraction digit
	always_comb begin
		den_sh  = rbc_pkg::PROD_W'(den_q) << k_q;
		ge      = (prod_q >= den_sh);
		prod_nx = ge ? (prod_q - den_sh) : prod_q;
		f_last  = ((rbc_pkg::FCNT_W'(fi_q) + rbc_pkg::FCNT_W'(1)) == cfg.fcount);
	end

	assign out_free = !out_valid_q || digits.ready;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		o_digit  = '0;
		o_last   = 1'b0;
		o_bad    = 1'b0;
		o_ovf    = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			rbc_pkg::ST_TAKE: begin
				if (!empty) begin
					pop = 1'b1;
					if (tok.last)
						state_d = rbc_pkg::ST_FINAL;
				end
			end
			rbc_pkg::ST_FINAL: begin
				if (err_q || fin_ovf)
					state_d = rbc_pkg::ST_FLAG;
				else if (cfg.frac)
					state_d = rbc_pkg::ST_FMUL;
				else
					state_d = rbc_pkg::ST_IDIV;
			end
			rbc_pkg::ST_FLAG: begin
				if (out_free) begin
					out_load = 1'b1;
					o_last   = 1'b1;
					o_bad    = err_q;
					o_ovf    = ovf_q;
					done     = 1'b1;
					state_d  = rbc_pkg::ST_TAKE;
				end
			end
			rbc_pkg::ST_IDIV: begin
				if (div_last) begin
					if (quo_nx == '0)
						state_d = rbc_pkg::ST_IREAD;
					else if (n_q == rbc_pkg::BUF_IDX_W'(rbc_pkg::OUT_CAP - 1))
						state_d = rbc_pkg::ST_FLAG;
				end
			end
			rbc_pkg::ST_IREAD: begin
				state_d = rbc_pkg::ST_IEMIT;
			end
			rbc_pkg::ST_IEMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					o_digit  = rdata_q;
					o_last   = (n_q == '0);
					if (n_q == '0) begin
						done    = 1'b1;
						state_d = rbc_pkg::ST_TAKE;
					end else begin
						state_d = rbc_pkg::ST_IREAD;
					end
				end
			end
			rbc_pkg::ST_FMUL: begin
				state_d = rbc_pkg::ST_FDIV;
			end
			rbc_pkg::ST_FDIV: begin
				if (k_q == '0)
					state_d = rbc_pkg::ST_FEMIT;
			end
			rbc_pkg::ST_FEMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					o_digit  = fq_q;
					o_last   = f_last;
					if (f_last) begin
						done    = 1'b1;
						state_d = rbc_pkg::ST_TAKE;
					end else begin
						state_d = rbc_pkg::ST_FMUL;
					end
				end
			end
			default: begin
				state_d = rbc_pkg::ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbc_pkg::ST_TAKE;
			acc_q       <= '0;
			den_q       <= rbc_pkg::DEN_W'(1);
			cnt_q       <= '0;
			err_q       <= 1'b0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			dstep_q     <= '0;
			k_q         <= '0;
			fi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (digits.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				rbc_pkg::ST_TAKE: begin
					if (pop && !(err_q || ovf_q)) begin
						if (tok.bad) begin
							err_q <= 1'b1;
						end else if (cnt_q >= rbc_pkg::CNT_W'(rbc_pkg::MAX_INPUT_DIGITS)) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + rbc_pkg::CNT_W'(1);
							if (cfg.frac) begin
								if (frac_ovf) begin
									ovf_q <= 1'b1;
								end else begin
									den_q <= den_mul[rbc_pkg::DEN_W-1:0];
									acc_q <= acc_new[rbc_pkg::VALUE_BITS-1:0];
								end
							end else if (int_ovf) begin
								ovf_q <= 1'b1;
							end else begin
								acc_q <= acc_new[rbc_pkg::VALUE_BITS-1:0];
							end
						end
					end
				end
				rbc_pkg::ST_FINAL: begin
					ovf_q   <= fin_ovf;
					n_q     <= '0;
					dstep_q <= '0;
					fi_q    <= '0;
				end
				rbc_pkg::ST_IDIV: begin
					if (div_last) begin
						dstep_q <= '0;
						if (quo_nx != '0) begin
							if (n_q == rbc_pkg::BUF_IDX_W'(rbc_pkg::OUT_CAP - 1))
								ovf_q <= 1'b1;
							else
								n_q <= n_q + rbc_pkg::BUF_IDX_W'(1);
						end
					end else begin
						dstep_q <= dstep_q + rbc_pkg::DCNT_W'(1);
					end
				end
				rbc_pkg::ST_IEMIT: begin
					if (out_load && (n_q != '0))
						n_q <= n_q - rbc_pkg::BUF_IDX_W'(1);
				end
				rbc_pkg::ST_FMUL: begin
					k_q <= rbc_pkg::FQ_CNT_W'(rbc_pkg::DIGIT_W - 1);
				end
				rbc_pkg::ST_FDIV: begin
					k_q <= k_q - rbc_pkg::FQ_CNT_W'(1);
				end
				rbc_pkg::ST_FEMIT: begin
					if (out_load && !f_last)
						fi_q <= fi_q + rbc_pkg::FIDX_W'(1);
				end
				default: begin
				end
			endcase

			if (done) begin
				acc_q <= '0;
				den_q <= rbc_pkg::DEN_W'(1);
				cnt_q <= '0;
				err_q <= 1'b0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rbc_pkg::ST_FINAL: begin
				quo_q <= acc_q;
				rem_q <= '0;
				r_q   <= acc_q;
			end
			rbc_pkg::ST_IDIV: begin
				quo_q <= quo_nx;
				rem_q <= div_last ? '0 : rem_nx;
				if (div_last)
					digit_mem[n_q] <= rem_nx;
			end
			rbc_pkg::ST_FMUL: begin
				prod_q <= rbc_pkg::PROD_W'(r_q) * rbc_pkg::PROD_W'(cfg.tgt_base);
				fq_q   <= '0;
			end
			rbc_pkg::ST_FDIV: begin
				prod_q <= prod_nx;
				fq_q   <= {fq_q[rbc_pkg::DIGIT_W-2:0], ge};
				if (k_q == '0)
					r_q <= prod_nx[rbc_pkg::VALUE_BITS-1:0];
			end
			default: begin
			end
		endcase

		rdata_q <= digit_mem[n_q];

		if (out_load) begin
			out_digit_q <= o_digit;
			out_last_q  <= o_last;
			out_bad_q   <= o_bad;
			out_ovf_q   <= o_ovf;
		end
	end

	assign digits.valid      = out_valid_q;
	assign digits.digit      = out_digit_q;
	assign digits.last_digit = out_last_q;
	assign digits.bad_digit  = out_bad_q;
	assign digits.overflow   = out_ovf_q;

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		den_q != '0)
		else $error("denominator reached zero");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbc_pkg::ST_IDIV) |-> ({1'b0, rem_q} < cfg.tgt_base))
		else $error("division remainder not below target base");

	a_frac_proper: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbc_pkg::ST_FMUL) |-> (rbc_pkg::DEN_W'(r_q) < den_q))
		else $error("fraction remainder not below denominator");

	a_fdiv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbc_pkg::ST_FDIV) |=>
		(prod_q < (rbc_pkg::PROD_W'(den_q) << $past(k_q))))
		else $error("restoring step left remainder too large");

	a_flag_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_bad_q || out_ovf_q)) |->
		(out_last_q && (out_digit_q == '0)))
		else $error("flagged result not a lone zero digit");
`endif

endmodule

`default_nettype wire
